// File: src/sipq_pkg.sv
// Package for the sorted-insert priority queue.
// Holds sizes, operation codes, the entry type and the cell control type; no dependencies.
package sipq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic shift_en;
    logic occupied;
    logic left_lt;
  } cell_ctrl_t;

endpackage

// File: src/sipq_cell.sv
// One storage cell of the sorted queue chain.
// Depends on sipq_pkg (entry_t, cell_ctrl_t).
module sipq_cell
  import sipq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  output entry_t     entry,
  output logic       lt
);

  entry_t entry_next;

  // held entry sorts strictly ahead of the incoming key
  assign lt = ctrl.occupied && (entry.key < new_entry.key);

  always_comb begin
    if (lt) begin
      entry_next = entry;
    end else if (ctrl.left_lt) begin
      entry_next = new_entry;
    end else begin
      entry_next = left_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      entry <= entry_next;
    end
  end

endmodule

// File: src/sorted_insert_priority_queue.sv
// Sorted-insert priority queue: a chain of CAPACITY cells in ascending key order.
// Result: registered, and presented in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle unless in_stall is high; all cells compare and shift in parallel.
// Output register stalls the input only while a result waits under out_stall.
// Reset (rst, synchronous): count to zero, no result pending; cell contents undefined.
// Depends on sipq_pkg and sipq_cell.
module sorted_insert_priority_queue
  import sipq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [KEY_W-1:0] key,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             removed_valid,
  output logic [KEY_W-1:0] removed_key,
  output logic [TAG_W-1:0] removed_tag,
  output logic             underflow,
  output logic             overflow,
  output logic [OCC_W-1:0] occupancy,
  output logic             is_empty
);

  logic             in_acc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_m1;
  logic             full;
  logic             empty;
  logic             do_shift;
  op_t              op_in;
  entry_t           new_entry;
  entry_t           cells [CAPACITY];
  logic             lt    [CAPACITY];
  entry_t           last_entry;

  logic             r_valid;
  logic [KEY_W-1:0] r_key;
  logic [TAG_W-1:0] r_tag;
  logic             r_under;
  logic             r_over;

  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign op_in     = op_t'(op);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign do_shift  = in_acc && (op_in == OP_INSERT) && !full;
  assign new_entry = '{key: key, tag: tag};
  assign count_m1  = count - CNT_W'(1);
  assign last_entry = cells[count_m1[IDX_W-1:0]];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     left_entry;

    assign ctrl.shift_en = do_shift;
    assign ctrl.occupied = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      assign ctrl.left_lt = 1'b1;
      assign left_entry   = new_entry;
    end else begin : g_body
      assign ctrl.left_lt = lt[i-1];
      assign left_entry   = cells[i-1];
    end

    sipq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .left_entry (left_entry),
      .entry      (cells[i]),
      .lt         (lt[i])
    );
  end

  always_comb begin
    count_next = count;
    r_valid    = 1'b0;
    r_key      = '0;
    r_tag      = '0;
    r_under    = 1'b0;
    r_over     = 1'b0;
    unique case (op_in)
      OP_INSERT: begin
        if (full) begin
          r_over = 1'b1;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          r_under = 1'b1;
        end else begin
          count_next = count_m1;
          r_valid    = 1'b1;
          r_key      = last_entry.key;
          r_tag      = last_entry.tag;
        end
      end
      OP_CLEAR: count_next = '0;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      removed_valid <= r_valid;
      removed_key   <= r_key;
      removed_tag   <= r_tag;
      underflow     <= r_under;
      overflow      <= r_over;
      occupancy     <= OCC_W'(count_next);
      is_empty      <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    do_shift |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow count");

  a_under: assert property (@(posedge clk) disable iff (rst)
    in_acc && op_in == OP_REMOVE && empty |=> out_valid && underflow && !removed_valid)
    else $error("remove on empty not flagged");

  a_over_stable: assert property (@(posedge clk) disable iff (rst)
    in_acc && op_in == OP_INSERT && full |=> count == $past(count) && overflow)
    else $error("insert when full changed queue");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> count == $past(count))
    else $error("count changed without transaction");

endmodule
